// ===== rtl/swam_pkg.sv =====
// package for the sliding window average block
// holds item types, fixed field widths and the controller state type
`timescale 1ns / 1ps
`default_nettype none

package swam_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int WINDOW_REG_W = 13;
    localparam int OUT_W        = 24;

    localparam logic [WINDOW_REG_W-1:0] WINDOW_RESET = 13'd60;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                start_series;
    } t_in_item;

    typedef struct packed {
        logic [OUT_W-1:0] window_average;
        logic [OUT_W-1:0] max_average;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_DIVIDE
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/swam_stream_if.sv =====
// valid/ready stream channel carrying one item of a given payload type
// used for the input and result channels, payload types come from swam_pkg
`timescale 1ns / 1ps
`default_nettype none

interface swam_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/swam_div.sv =====
// restoring serial divider, one quotient bit per cycle
// standalone, used twice by the top level
`timescale 1ns / 1ps
`default_nettype none

module swam_div #(
    parameter int DW = 36,
    parameter int VW = 13
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    output logic               o_busy,
    output logic [DW-1:0]      o_quotient
);

    localparam int CNTW = $clog2(DW + 1);

    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_q;
    logic [VW-1:0]   r_rem;
    logic [VW-1:0]   r_div;
    logic [VW:0]     shifted;
    logic            ge;

    assign shifted    = {r_rem, r_q[DW-1]};
    assign ge         = shifted >= {1'b0, r_div};
    assign o_busy     = r_cnt != '0;
    assign o_quotient = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNTW'(DW);
        end else if (o_busy) begin
            r_cnt <= r_cnt - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (o_busy) begin
            r_q   <= {r_q[DW-2:0], ge};
            r_rem <= ge ? VW'(shifted - {1'b0, r_div}) : VW'(shifted);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sliding_window_average_with_max.sv =====
// an item passes the read and update states and gives no result before the window
// is full; otherwise the dividers run and their quotients go to the result register
// one item at a time, set by the serial dividers
// the result register holds a finished item while the next one is taken
// synchronous active-low reset: window 60, series cleared, sample ring left unset
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_average_with_max #(
    parameter int MAX_WINDOW    = 4096,
    parameter int FRACTION_BITS = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [swam_pkg::WINDOW_REG_W-1:0]   i_cfg_wdata,
    swam_stream_if.sink                              i_in,
    swam_stream_if.source                            o_out
);

    localparam int AW = $clog2(MAX_WINDOW);
    localparam int WW = $clog2(MAX_WINDOW + 1);
    localparam int SW = swam_pkg::SAMPLE_W + AW;
    localparam int DW = SW + FRACTION_BITS;
    localparam int OW = swam_pkg::OUT_W;
    localparam int XW = WW + 1;

    function automatic logic [WW-1:0] eff_window(
        input logic [swam_pkg::WINDOW_REG_W-1:0] v
    );
        logic [WW-1:0] w;
        if (v == '0) begin
            w = WW'(1);
        end else if (32'(v) > 32'(MAX_WINDOW)) begin
            w = WW'(MAX_WINDOW);
        end else begin
            w = WW'(v);
        end
        return w;
    endfunction

    swam_pkg::t_state r_state, n_state;

    logic [WW-1:0] r_window;
    logic [AW-1:0] r_slot;
    logic [WW-1:0] r_fill;
    logic [SW-1:0] r_sum;
    logic [SW-1:0] r_max;
    logic [swam_pkg::SAMPLE_W-1:0] r_sample;
    logic          r_restart;
    logic [swam_pkg::SAMPLE_W-1:0] r_rd_data;
    logic          r_out_valid;
    swam_pkg::t_out_item r_out;

    logic [swam_pkg::SAMPLE_W-1:0] ring [MAX_WINDOW];

    logic [AW-1:0] e_slot;
    logic [WW-1:0] e_fill;
    logic [SW-1:0] e_sum;
    logic [SW-1:0] e_max;
    logic          full_before;
    logic          full_after;
    logic [XW-1:0] slot_x;
    logic [XW-1:0] win_x;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] n_slot;
    logic [WW-1:0] n_fill;
    logic [SW-1:0] n_sum;
    logic [SW-1:0] n_max;

    logic          in_accept;
    logic          div_start;
    logic          load_out;
    logic          avg_busy;
    logic          max_busy;
    logic [DW-1:0] avg_q;
    logic [DW-1:0] max_q;

    // restart applies before the item
    assign e_slot = r_restart ? '0 : r_slot;
    assign e_fill = r_restart ? '0 : r_fill;
    assign e_sum  = r_restart ? '0 : r_sum;
    assign e_max  = r_restart ? '0 : r_max;

    assign full_before = e_fill >= r_window;

    // oldest sample slot, modulo ring depth
    assign slot_x  = XW'(e_slot);
    assign win_x   = XW'(r_window);
    assign rd_addr = (slot_x >= win_x) ? AW'(slot_x - win_x)
                                       : AW'(slot_x + XW'(MAX_WINDOW) - win_x);

    assign n_slot = (e_slot == AW'(MAX_WINDOW - 1)) ? '0 : e_slot + AW'(1);
    assign n_fill = full_before ? e_fill : e_fill + WW'(1);
    assign n_sum  = e_sum - (full_before ? SW'(r_rd_data) : '0) + SW'(r_sample);
    assign n_max  = (n_sum > e_max) ? n_sum : e_max;
    assign full_after = n_fill >= r_window;

    assign in_accept = i_in.valid && i_in.ready;
    assign div_start = (r_state == swam_pkg::S_UPDATE) && full_after;

    always_comb begin
        n_state     = r_state;
        i_in.ready  = 1'b0;
        load_out    = 1'b0;
        unique case (r_state)
            swam_pkg::S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_state = swam_pkg::S_READ;
                end
            end
            swam_pkg::S_READ: begin
                n_state = swam_pkg::S_UPDATE;
            end
            swam_pkg::S_UPDATE: begin
                n_state = full_after ? swam_pkg::S_DIVIDE : swam_pkg::S_IDLE;
            end
            swam_pkg::S_DIVIDE: begin
                if (!avg_busy && !max_busy && (!r_out_valid || o_out.ready)) begin
                    load_out = 1'b1;
                    n_state  = swam_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = swam_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swam_pkg::S_IDLE;
            r_window    <= eff_window(swam_pkg::WINDOW_RESET);
            r_slot      <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_max       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_window <= eff_window(i_cfg_wdata);
                r_slot   <= '0;
                r_fill   <= '0;
                r_sum    <= '0;
                r_max    <= '0;
            end else if (r_state == swam_pkg::S_UPDATE) begin
                r_slot <= n_slot;
                r_fill <= n_fill;
                r_sum  <= n_sum;
                r_max  <= full_after ? n_max : e_max;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_sample  <= i_in.payload.sample;
            r_restart <= i_in.payload.start_series;
        end
        if (load_out) begin
            r_out.window_average <= OW'(avg_q);
            r_out.max_average    <= OW'(max_q);
        end
    end

    // sample ring, registered read
    always_ff @(posedge i_clk) begin
        if (r_state == swam_pkg::S_UPDATE) begin
            ring[e_slot] <= r_sample;
        end
        r_rd_data <= ring[rd_addr];
    end

    swam_div #(
        .DW (DW),
        .VW (WW)
    ) u_avg_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (DW'(n_sum) << FRACTION_BITS),
        .i_divisor  (r_window),
        .o_busy     (avg_busy),
        .o_quotient (avg_q)
    );

    swam_div #(
        .DW (DW),
        .VW (WW)
    ) u_max_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (DW'(n_max) << FRACTION_BITS),
        .i_divisor  (r_window),
        .o_busy     (max_busy),
        .o_quotient (max_q)
    );

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

`default_nettype wire

// ===== rtl/swam_checker.sv =====
// port-level checks for the sliding window average block
// bound to the top level, uses swam_pkg result type
`timescale 1ns / 1ps
`default_nettype none

module swam_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                i_in_ready,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire swam_pkg::t_out_item i_out_payload
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_payload))
        else $error("stalled result changed");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item taken while one is at work");

    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid) ##1 !$rose(i_out_valid))
        else $error("result appeared too soon after item");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind sliding_window_average_with_max swam_checker u_swam_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);

`default_nettype wire

// ===== dv/window_average_checker.sv =====
// result checker for the sliding window average block: predicts each result from the
// accepted input items and register writes, and compares it with the result channel
// depends on swam_pkg for item types and field widths
`timescale 1ns / 1ps

module window_average_checker #(
    parameter int MAX_WINDOW    = 4096,
    parameter int FRACTION_BITS = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [swam_pkg::WINDOW_REG_W-1:0] i_cfg_wdata,
    input  wire logic                              i_in_valid,
    input  wire logic                              i_in_ready,
    input  wire swam_pkg::t_in_item                i_in_item,
    input  wire logic                              i_out_valid,
    input  wire logic                              i_out_ready,
    input  wire swam_pkg::t_out_item               i_out_item,
    output int                                     o_fail_count,
    output int                                     o_pending
);
    import swam_pkg::*;

    localparam int SLOT_W   = $clog2(MAX_WINDOW);
    localparam int SUM_W    = SAMPLE_W + $clog2(MAX_WINDOW);
    localparam int SCALED_W = SUM_W + FRACTION_BITS;
    localparam int MAX_REPORTS = 40;

    logic [SAMPLE_W-1:0]     sample_ring [MAX_WINDOW];
    logic [SLOT_W-1:0]       write_slot;
    int                      fill_count;
    logic [SUM_W-1:0]        running_sum;
    logic [SUM_W-1:0]        peak_sum;
    logic [WINDOW_REG_W-1:0] window_len;
    t_out_item               expected_averages [$];
    int                      fail_count = 0;

    function automatic int effective_window(logic [WINDOW_REG_W-1:0] wlen);
        if (wlen == '0) return 1;
        if (int'(wlen) > MAX_WINDOW) return MAX_WINDOW;
        return int'(wlen);
    endfunction

    function automatic logic [OUT_W-1:0] scaled_average(logic [SUM_W-1:0] sum, int wlen);
        logic [SCALED_W-1:0] num;
        num = SCALED_W'(sum) << FRACTION_BITS;
        return OUT_W'(num / SCALED_W'(wlen));
    endfunction

    function automatic void restart_series();
        write_slot  = '0;
        fill_count  = 0;
        running_sum = '0;
        peak_sum    = '0;
    endfunction

    task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                   input logic [OUT_W-1:0] want);
        if (fail_count < MAX_REPORTS) begin
            $display("checker: %s, got %0d expected %0d at %0t ns", what, got, want, $realtime);
        end
        fail_count++;
    endtask

    task automatic advance_window(input t_in_item item);
        int        eff;
        int        old_slot;
        t_out_item avg;
        eff = effective_window(window_len);
        if (item.start_series) restart_series();
        if (fill_count >= eff) begin
            old_slot = (int'(write_slot) + MAX_WINDOW - eff) % MAX_WINDOW;
            running_sum = running_sum - SUM_W'(sample_ring[old_slot]);
        end else begin
            fill_count++;
        end
        sample_ring[write_slot] = item.sample;
        running_sum = running_sum + SUM_W'(item.sample);
        if (int'(write_slot) == MAX_WINDOW - 1) write_slot = '0;
        else write_slot = write_slot + 1'b1;
        if (fill_count >= eff) begin
            if (running_sum > peak_sum) peak_sum = running_sum;
            avg.window_average = scaled_average(running_sum, eff);
            avg.max_average    = scaled_average(peak_sum, eff);
            expected_averages.push_back(avg);
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (expected_averages.size() == 0) begin
            report_mismatch("result with no item pending", got.window_average, '0);
        end else begin
            want = expected_averages.pop_front();
            if (got.window_average !== want.window_average)
                report_mismatch("window_average", got.window_average, want.window_average);
            if (got.max_average !== want.max_average)
                report_mismatch("max_average", got.max_average, want.max_average);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            window_len = WINDOW_RESET;
            restart_series();
            expected_averages.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_result(i_out_item);
            if (i_cfg_we) begin
                window_len = i_cfg_wdata;
                restart_series();
            end
            if (i_in_valid && i_in_ready) advance_window(i_in_item);
        end
        o_pending    <= expected_averages.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== dv/testbench.sv =====
// top of the sliding window average testbench: clock, reset, register writes and
// randomized item traffic on both channels, with the verdict at the end
// depends on swam_pkg, swam_stream_if, the block and window_average_checker
`timescale 1ns / 1ps

module testbench;
    import swam_pkg::*;

    localparam int MAX_WINDOW    = 4096;
    localparam int FRACTION_BITS = 8;
    localparam int DRAIN_CYCLES  = 100;
    localparam int HOLD_CYCLES   = 1500;
    localparam int CYCLE_LIMIT   = 2000000;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [WINDOW_REG_W-1:0] cfg_wdata;
    int                      fail_count;
    int                      pending;
    int                      cycle_count = 0;
    int                      idle_pct = 0;
    int                      stall_pct = 0;
    int                      hold_requests = 0;

    swam_stream_if #(.t_payload(t_in_item))  in_ch ();
    swam_stream_if #(.t_payload(t_out_item)) out_ch ();

    sliding_window_average_with_max #(
        .MAX_WINDOW    (MAX_WINDOW),
        .FRACTION_BITS (FRACTION_BITS)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    window_average_checker #(
        .MAX_WINDOW    (MAX_WINDOW),
        .FRACTION_BITS (FRACTION_BITS)
    ) i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_item    (in_ch.payload),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_item   (out_ch.payload),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // result side: random stalls plus an occasional long hold-off
    initial begin : result_sink
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return SAMPLE_W'($urandom_range(15));
            3: return '1 - SAMPLE_W'($urandom_range(15));
            default: return SAMPLE_W'($urandom_range(16'hFFFF));
        endcase
    endfunction

    function automatic int series_length(int eff);
        if ($urandom_range(9) == 0) return $urandom_range(1, eff);
        return $urandom_range(eff, 3 * eff + 8);
    endfunction

    task automatic send_item(input logic [SAMPLE_W-1:0] smp, input logic restart);
        t_in_item item;
        item.sample       = smp;
        item.start_series = restart;
        if ($urandom_range(99) < idle_pct) begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            while ($urandom_range(99) < idle_pct) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid   <= 1'b1;
        in_ch.payload <= item;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    task automatic settle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [WINDOW_REG_W-1:0] wlen);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= wlen;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_series(input int eff, input int n_items, input bit single_series);
        int   left;
        logic restart;
        left = single_series ? n_items + 1 : series_length(eff);
        for (int k = 0; k < n_items; k++) begin
            restart = 1'b0;
            if (left == 0) begin
                restart = 1'b1;
                left = series_length(eff);
            end else if (k == 0 && !single_series) begin
                restart = 1'($urandom_range(1));
            end
            left--;
            send_item(random_sample(), restart);
        end
    endtask

    task automatic run_phase(input logic [WINDOW_REG_W-1:0] wlen, input int n_items,
                             input int idle, input int stall, input bit pressure,
                             input bit single_series);
        int eff;
        settle();
        idle_pct  = idle;
        stall_pct = stall;
        write_window(wlen);
        if (pressure) hold_requests++;
        eff = (wlen == '0) ? 1 : ((int'(wlen) > MAX_WINDOW) ? MAX_WINDOW : int'(wlen));
        send_series(eff, n_items, single_series);
    endtask

    initial begin : stimulus
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // window from reset
        send_series(int'(WINDOW_RESET), 100, 0);

        settle();
        write_window(13'd3);
        send_item('1, 1'b0);
        send_item('1, 1'b0);
        send_item('1, 1'b0);
        send_item('0, 1'b0);
        send_item('0, 1'b0);
        send_item('0, 1'b0);
        send_item(16'd1, 1'b1);
        send_item(16'd2, 1'b0);
        send_item(16'd4, 1'b0);
        send_item('0, 1'b1);
        send_item('0, 1'b0);
        // register write restarts a partial series
        settle();
        write_window(13'd3);
        send_item(16'h8000, 1'b0);
        send_item(16'h5555, 1'b0);
        send_item(16'hAAAA, 1'b0);
        // zero window acts as one
        settle();
        write_window(13'd0);
        send_item('1, 1'b0);
        send_item('0, 1'b0);
        send_item(16'd1, 1'b1);
        send_item(16'hFFFE, 1'b0);

        run_phase(13'd1, 150, 0, 0, 1'b0, 1'b0);
        run_phase(13'd2, 150, 67, 0, 1'b0, 1'b0);
        run_phase(WINDOW_REG_W'($urandom_range(3, 16)), 150, 0, 67, 1'b0, 1'b0);
        run_phase(WINDOW_REG_W'($urandom_range(17, 64)), 120, 36, 36, 1'b0, 1'b0);
        run_phase(13'd5, 150, 0, 0, 1'b1, 1'b0);
        run_phase(13'd0, 60, 36, 36, 1'b0, 1'b0);
        run_phase(13'd7, 100, 67, 67, 1'b0, 1'b0);
        // largest window, stream too short for a result
        run_phase(13'd4096, 40, 0, 0, 1'b0, 1'b1);
        // saturated window, stream too short for a result
        run_phase(13'd8191, 40, 0, 0, 1'b0, 1'b1);

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
